// File: rtl/core/gba_pkg.sv
// Shared types and constants for the GHASH block accumulator.
// No dependencies; imported by gba_gf128_mul and ghash_block_accumulator.
package gba_pkg;

  // One GHASH block, digest or key: 128 bits, byte 0 in bits [127:120]
  typedef logic [127:0] gba_blk_t;
  typedef logic [63:0]  gba_half_t;

  // Configuration port geometry: 64-bit registers at byte addresses 8*i
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 64;

  // Register indexes (paddr[3] selects the register)
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  // Reduction polynomial x^128 + x^7 + x^2 + x + 1: degree and product width
  localparam int unsigned PolyDeg = 128;
  localparam int unsigned ProdW   = 2 * PolyDeg - 1;

endpackage

// File: rtl/core/gba_gf128_mul.sv
// Combinational GF(2^128) multiplier in GCM bit order.
// Depends on gba_pkg for the block type and field constants.
module gba_gf128_mul import gba_pkg::*; (
  input  gba_blk_t a,
  input  gba_blk_t b,
  output gba_blk_t z
);

  logic [PolyDeg-1:0] a_p;
  logic [PolyDeg-1:0] b_p;
  logic [ProdW-1:0]   prod;
  logic [PolyDeg-2:0] hi;
  logic [PolyDeg+6:0] fold1;
  logic [6:0]         hi2;
  logic [PolyDeg-1:0] red;

  // GCM order: the leftmost bit is the x^0 coefficient, so flip into
  // ordinary polynomial order
  always_comb begin
    for (int i = 0; i < PolyDeg; i++) begin
      a_p[i] = a[PolyDeg-1-i];
      b_p[i] = b[PolyDeg-1-i];
    end
  end

  // Carry-less product: each product bit is an independent XOR tree
  always_comb begin
    for (int k = 0; k < ProdW; k++) begin
      prod[k] = 1'b0;
      for (int i = 0; i < PolyDeg; i++) begin
        if ((k >= i) && ((k - i) < PolyDeg)) begin
          prod[k] = prod[k] ^ (a_p[i] & b_p[k-i]);
        end
      end
    end
  end

  // Reduce: x^128 = x^7 + x^2 + x + 1, folded twice
  always_comb begin
    hi    = prod[ProdW-1:PolyDeg];
    fold1 = {7'b0, prod[PolyDeg-1:0]}
          ^ {8'b0, hi}
          ^ {7'b0, hi, 1'b0}
          ^ {6'b0, hi, 2'b0}
          ^ {1'b0, hi, 7'b0};
    hi2   = fold1[PolyDeg+6:PolyDeg];
    red   = fold1[PolyDeg-1:0]
          ^ {121'b0, hi2}
          ^ {120'b0, hi2, 1'b0}
          ^ {119'b0, hi2, 2'b0}
          ^ {114'b0, hi2, 7'b0};
  end

  // Back to GCM order
  always_comb begin
    for (int i = 0; i < PolyDeg; i++) begin
      z[PolyDeg-1-i] = red[i];
    end
  end

endmodule

// File: rtl/core/ghash_block_accumulator.sv
// GHASH block accumulator top level: input register, GF(2^128) update, result register.
// Depends on gba_pkg and gba_gf128_mul.

// Absorbs one 128-bit word per clock while the output is not stalled,
// since the combinational GF(2^128) multiply feeds the accumulator back on
// itself, and returns the running GHASH value Y = (Y xor X) * H after
// every word. An accepted word sits in the input register; the multiply
// result is loaded into the result register once that register is free,
// and the digest then shows on out_digest_high and out_digest_low.
// While out_ready is low, one further word waits in the input register
// and in_ready then drops. in_first_block clears the accumulator
// before the word is absorbed. The hash subkey H is written through the
// APB port: hash_key_high at byte address 0x0, hash_key_low at 0x8, each
// 64 bits, byte 0 of H in the top byte of hash_key_high. Write the key
// only while the block is idle; a new key applies to the next word and
// the accumulator is kept. Reset clears the key and the accumulator.
module ghash_block_accumulator import gba_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         in_block_high,
  input  logic [63:0]         in_block_low,
  input  logic                in_first_block,
  // digests
  output logic                out_valid,
  input  logic                out_ready,
  output logic [63:0]         out_digest_high,
  output logic [63:0]         out_digest_low,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  gba_half_t key_high_r;
  gba_half_t key_low_r;
  gba_blk_t  acc_r;
  gba_blk_t  acc_nxt;
  gba_blk_t  mul_in;

  logic      s1_valid_r;
  gba_blk_t  s1_blk_r;
  logic      s1_first_r;

  logic      out_valid_r;
  gba_blk_t  out_blk_r;

  logic      out_free;
  logic      advance;
  logic      cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_KEY_HIGH: key_high_r <= pwdata;
        REG_KEY_LOW:  key_low_r  <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_KEY_HIGH: prdata = key_high_r;
      REG_KEY_LOW:  prdata = key_low_r;
      default:      prdata = '0;
    endcase
  end

  // Handshake: input stage moves on whenever the result register is free
  assign out_free = ~out_valid_r | out_ready;
  assign advance  = s1_valid_r & out_free;
  assign in_ready = ~s1_valid_r | out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_blk_r   <= {in_block_high, in_block_low};
      s1_first_r <= in_first_block;
    end
  end

  // Accumulator update: (Y xor X) * H, Y cleared on a first word
  assign mul_in = (s1_first_r ? '0 : acc_r) ^ s1_blk_r;

  gba_gf128_mul u_mul (
    .a (mul_in),
    .b ({key_high_r, key_low_r}),
    .z (acc_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (advance) begin
      acc_r <= acc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_blk_r <= acc_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digest_high = out_blk_r[127:64];
  assign out_digest_low  = out_blk_r[63:0];

  // Checks
  a_adv_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("word left the input stage without a digest");

  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(acc_r))
    else $error("accumulator changed without a word moving");

  a_digest_is_acc: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_blk_r == acc_r))
    else $error("digest differs from accumulator");

  a_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && key_high_r == '0 && key_low_r == '0) |=> (acc_r == '0))
    else $error("zero key gave nonzero digest");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("empty input stage refused a word");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for ghash_block_accumulator: GHASH words in, running digests out.
// Depends on gba_pkg (block types, register indexes, port widths) and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import gba_pkg::*;

  // one input word as it goes out on the in_* channel
  typedef struct packed {
    gba_half_t hi;
    gba_half_t lo;
    logic      first;
  } ghash_word_t;

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

  localparam int WordsPerPhase = 110;
  localparam int RandomPhases  = 5;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [63:0]         in_block_high  = '0;
  logic [63:0]         in_block_low   = '0;
  logic                in_first_block = 1'b0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [63:0]         out_digest_high;
  logic [63:0]         out_digest_low;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [CfgAddrW-1:0] paddr   = '0;
  logic [CfgDataW-1:0] pwdata  = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  ghash_block_accumulator DUT (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_block_high, .in_block_low, .in_first_block,
    .out_valid, .out_ready, .out_digest_high, .out_digest_low,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // words waiting to be sent, digests waiting to come back
  ghash_word_t words_pending[$];
  gba_blk_t    digests_due[$];

  // predictor state: hash subkey halves and running GHASH value
  gba_half_t key_high_q = '0;
  gba_half_t key_low_q  = '0;
  gba_blk_t  ghash_acc  = '0;

  int errors        = 0;
  int words_sent    = 0;
  int digests_seen  = 0;
  int key_settings  = 1;
  logic in_took     = 1'b0;

  // GF(2^128) product in GCM bit order: bit 127 is the x^0 coefficient
  function automatic gba_blk_t gf128_times(gba_blk_t x, gba_blk_t h);
    gba_blk_t z;
    gba_blk_t v;
    z = '0;
    v = h;
    for (int i = 127; i >= 0; i--) begin
      if (x[i]) z ^= v;
      v = v[0] ? ((v >> 1) ^ {8'hE1, 120'h0}) : (v >> 1);
    end
    return z;
  endfunction

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // sender: bursts of words separated by random gaps
  int send_burst = 1;
  int send_gap   = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 8) return $urandom_range(1, 4);
    return $urandom_range(5, 20);
  endfunction

  always @(negedge clk) begin : sender
    ghash_word_t nxt;
    if (!in_valid || in_took) begin
      if (send_gap > 0 || words_pending.size() == 0) begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap--;
      end else begin
        nxt = words_pending.pop_front();
        in_valid       <= 1'b1;
        in_block_high  <= nxt.hi;
        in_block_low   <= nxt.lo;
        in_first_block <= nxt.first;
        if (send_burst <= 1) begin
          send_burst = $urandom_range(1, 16);
          send_gap   = pick_gap();
        end else begin
          send_burst--;
        end
      end
    end
  end

  // receiver: a random stall pattern, picked anew for each run
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_hold = 0;
  logic     rx_flip = 1'b0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN: begin
        out_ready <= 1'b1;
      end
      RX_COIN: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      RX_SPARSE: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        if (rx_hold == 0) begin
          rx_hold = $urandom_range(1, 12);
          rx_flip = ~rx_flip;
        end
        rx_hold--;
        out_ready <= rx_flip;
      end
    endcase
  end

  // monitor: key writes, accepted words and returned digests
  always @(posedge clk) begin : monitor
    gba_blk_t y;
    gba_blk_t want;
    in_took <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[3] == REG_KEY_LOW) key_low_q = pwdata;
        else key_high_q = pwdata;
      end
      if (in_valid && in_ready) begin
        y = in_first_block ? '0 : ghash_acc;
        y ^= {in_block_high, in_block_low};
        ghash_acc = gf128_times(y, {key_high_q, key_low_q});
        digests_due.push_back(ghash_acc);
        words_sent++;
      end
      if (out_valid && out_ready) begin
        digests_seen++;
        if (digests_due.size() == 0) begin
          $error("unexpected digest %h_%h", out_digest_high, out_digest_low);
          errors++;
        end else begin
          want = digests_due.pop_front();
          if (out_digest_high !== want[127:64]) begin
            $error("digest_high: expected %h, got %h", want[127:64], out_digest_high);
            errors++;
          end
          if (out_digest_low !== want[63:0]) begin
            $error("digest_low: expected %h, got %h", want[63:0], out_digest_low);
            errors++;
          end
        end
      end
    end
  end

  // APB write of one key half, then read it back
  task automatic key_write(input logic sel, input gba_half_t val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CfgAddrW'({sel, 3'b000});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val) begin
      $error("key readback: expected %h, got %h", val, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_key(input gba_half_t hi, input gba_half_t lo);
    key_write(REG_KEY_HIGH, hi);
    key_write(REG_KEY_LOW, lo);
    key_settings++;
  endtask

  // wait until every word is in and every digest is back; the small delay
  // lets the sender's update at the same falling edge settle first
  task automatic drain();
    do begin
      @(negedge clk);
      #1;
    end while (words_pending.size() != 0 || in_valid || digests_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_word(input gba_half_t hi, input gba_half_t lo, input logic first);
    ghash_word_t w;
    w.hi    = hi;
    w.lo    = lo;
    w.first = first;
    words_pending.push_back(w);
  endtask

  function automatic gba_half_t rand_half();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // stimulus
  initial begin : stimulus
    int n;
    int len;
    @(posedge rst_n);

    // key still zero from reset: all digests zero
    push_word('1, '1, 1'b1);
    push_word(rand_half(), rand_half(), 1'b0);
    push_word(rand_half(), rand_half(), 1'b1);
    drain();

    // identity key: digest is just the xor chain of the words
    set_key(64'h8000_0000_0000_0000, 64'h0);
    push_word(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);
    push_word('1, '1, 1'b0);
    push_word('0, '0, 1'b0);
    push_word(64'h8000_0000_0000_0000, 64'h1, 1'b0);
    push_word('1, '1, 1'b1);
    drain();

    // all-ones key
    set_key('1, '1);
    push_word('1, '1, 1'b1);
    push_word('1, '1, 1'b0);
    push_word('0, '0, 1'b0);
    push_word(64'h0, 64'h1, 1'b0);
    push_word(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0);
    drain();

    // key x^127: every product needs the reduction step
    set_key(64'h0, 64'h1);
    push_word(64'h0, 64'h1, 1'b1);
    push_word(64'h0, 64'h1, 1'b0);
    push_word(64'h8000_0000_0000_0000, 64'h0, 1'b0);
    push_word('1, '0, 1'b0);
    drain();

    // key changed between words of one message: accumulator carries over
    key_write(REG_KEY_LOW, {$urandom, $urandom});
    key_settings++;
    push_word(rand_half(), rand_half(), 1'b0);
    push_word(rand_half(), rand_half(), 1'b0);
    push_word(rand_half(), rand_half(), 1'b0);
    drain();

    // random phases: mostly whole messages, some stray words
    for (int p = 0; p < RandomPhases; p++) begin
      if (p == 2) begin
        key_write(REG_KEY_HIGH, {$urandom, $urandom});
        key_settings++;
      end else begin
        set_key(rand_half(), rand_half());
      end
      n = 0;
      while (n < WordsPerPhase) begin
        if ($urandom_range(0, 99) < 85) begin
          len = $urandom_range(1, 13);
          for (int k = 0; k < len; k++) push_word(rand_half(), rand_half(), k == 0);
          n += len;
        end else begin
          push_word(rand_half(), rand_half(), 1'($urandom_range(0, 1)));
          n++;
        end
      end
      drain();
    end

    repeat (10) @(negedge clk);
    $display("summary: %0d words over %0d key settings, %0d digests compared",
             words_sent, key_settings, digests_seen);
    $display("summary: zero, identity, all-ones and reduction keys plus random keys");
    if (errors == 0 && digests_due.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      if (digests_due.size() != 0) $error("%0d digests never arrived", digests_due.size());
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
